// ----- design/wed_pkg.sv -----
// Shared types and constants for the weighted edit distance core.
package wed_pkg;

  // Field widths fixed by the interface
  localparam int DIST_W = 27;
  localparam int CHAR_W = 8;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Request codes
  localparam logic [1:0] REQ_WORD    = 2'd0;
  localparam logic [1:0] REQ_QUERY   = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;
  localparam logic [1:0] REQ_NOP     = 2'd3;

  // log2 values: 3 integer bits, 32 fraction bits
  localparam int LOG_FRAC = 32;
  localparam int LOG_W    = LOG_FRAC + 3;

  // 5*ln(2) with 32 fraction bits, split in two halves for the multiplier
  localparam int MUL_SPLIT = 17;
  localparam logic [33:0] FIVE_LN2_Q32 = 34'd14885222359;
  localparam logic [MUL_SPLIT-1:0] K_LO = FIVE_LN2_Q32[MUL_SPLIT-1:0];
  localparam logic [MUL_SPLIT-1:0] K_HI = FIVE_LN2_Q32[2*MUL_SPLIT-1:MUL_SPLIT];

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } wed_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              length_error;
  } wed_out_t;

  // Cost unit result: full cost and cost divided by the string length
  typedef struct packed {
    logic [DIST_W-1:0] full;
    logic [DIST_W-1:0] scaled;
  } wed_cost_t;

  // Per-position query costs: substitution and deletion
  typedef struct packed {
    logic [DIST_W-1:0] sub;
    logic [DIST_W-1:0] del;
  } wed_qcost_t;

endpackage

// ----- design/wed_cost_unit.sv -----
// Position cost unit: log2 by repeated squaring, scale by 5*ln2, divide by length.
module wed_cost_unit #(
  parameter int MAX_LEN   = 32,
  parameter int FRAC_BITS = 16,
  localparam int LEN_W    = $clog2(MAX_LEN + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [LEN_W-1:0]     pos,
  input  logic [LEN_W-1:0]     len,
  output logic                 done,
  output wed_pkg::wed_cost_t   result
);
  import wed_pkg::*;

  localparam int XW    = LEN_W + 1;
  localparam int SH    = 56 - FRAC_BITS;
  localparam int PROD_W = 62;

  localparam logic [2:0] CU_IDLE = 3'd0;
  localparam logic [2:0] CU_LOGA = 3'd1;
  localparam logic [2:0] CU_LOGB = 3'd2;
  localparam logic [2:0] CU_MLO  = 3'd3;
  localparam logic [2:0] CU_MHI  = 3'd4;
  localparam logic [2:0] CU_SUM  = 3'd5;
  localparam logic [2:0] CU_DIV  = 3'd6;

  localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'(1) << (SH - 1);

  // Index of the leading one
  function automatic logic [2:0] msb_index(input logic [XW-1:0] x);
    logic [2:0] e;
    e = '0;
    for (int b = 0; b < XW; b++) begin
      if (x[b]) e = 3'(b);
    end
    return e;
  endfunction

  // Mantissa with the leading one at bit 30
  function automatic logic [30:0] norm(input logic [XW-1:0] x, input logic [2:0] e);
    logic [XW+29:0] w;
    w = {x, 30'd0};
    w = w >> e;
    return w[30:0];
  endfunction

  logic [2:0]             state_r, state_nxt;
  logic [4:0]             cnt_r;
  logic                   done_r;
  logic [LEN_W-1:0]       pos_r, len_r;
  logic [30:0]            m_r;
  logic [2:0]             e_r;
  logic [LOG_FRAC-1:0]    frac_r;
  logic [LOG_W-1:0]       loga_r;
  logic [DIST_W-1:0]      dh_r;
  logic [43:0]            pl_r, ph_r;
  logic [DIST_W-1:0]      cost_r;
  logic [DIST_W-1:0]      dv_r;
  logic [LEN_W-1:0]       rem_r;

  logic [XW-1:0]          x_a, x_b;
  logic [30:0]            mul_a, mul_b;
  logic [PROD_W-1:0]      mul_p;
  logic [31:0]            sq_top;
  logic [30:0]            m_step;
  logic [LOG_FRAC-1:0]    frac_step;
  logic [LOG_W-1:0]       logb;
  logic [LOG_W-1:0]       ldiff;
  logic [PROD_W-1:0]      psum, pshift;
  logic [DIST_W-1:0]      cost_sat;
  logic [LEN_W:0]         rem_sh;
  logic                   q_bit;
  logic [LEN_W:0]         rem_sub;

  assign x_a = XW'(len) + XW'(2);
  assign x_b = XW'(pos_r) + XW'(1);

  // Shared multiplier: squaring during log2, constant halves afterwards
  always_comb begin
    mul_a = m_r;
    mul_b = m_r;
    case (state_r)
      CU_MLO: begin
        mul_a = 31'(dh_r);
        mul_b = 31'(K_LO);
      end
      CU_MHI: begin
        mul_a = 31'(dh_r);
        mul_b = 31'(K_HI);
      end
      default: ;
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // One fraction bit per squaring
  assign sq_top    = mul_p[61:30];
  assign m_step    = sq_top[31] ? sq_top[31:1] : sq_top[30:0];
  assign frac_step = {frac_r[LOG_FRAC-2:0], sq_top[31]};

  // Log difference, truncated to 24 fraction bits
  assign logb  = {e_r, frac_step};
  assign ldiff = (loga_r > logb) ? (loga_r - logb) : '0;

  // Recombine partial products, round, saturate
  assign psum     = (PROD_W'(ph_r) << MUL_SPLIT) + PROD_W'(pl_r) + ROUND_ADD;
  assign pshift   = psum >> SH;
  assign cost_sat = (pshift > PROD_W'(DIST_MAX)) ? DIST_MAX : pshift[DIST_W-1:0];

  // Restoring divide step
  assign rem_sh  = {rem_r, dv_r[DIST_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, len_r});
  assign rem_sub = rem_sh - {1'b0, len_r};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CU_IDLE: if (start) state_nxt = CU_LOGA;
      CU_LOGA: if (cnt_r == 5'd31) state_nxt = CU_LOGB;
      CU_LOGB: if (cnt_r == 5'd31) state_nxt = CU_MLO;
      CU_MLO:  state_nxt = CU_MHI;
      CU_MHI:  state_nxt = CU_SUM;
      CU_SUM:  state_nxt = CU_DIV;
      CU_DIV:  if (cnt_r == 5'(DIST_W - 1)) state_nxt = CU_IDLE;
      default: state_nxt = CU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CU_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == CU_DIV) && (cnt_r == 5'(DIST_W - 1));
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      CU_IDLE: begin
        if (start) begin
          pos_r  <= pos;
          len_r  <= len;
          e_r    <= msb_index(x_a);
          m_r    <= norm(x_a, msb_index(x_a));
          frac_r <= '0;
          cnt_r  <= '0;
        end
      end
      CU_LOGA: begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          loga_r <= {e_r, frac_step};
          e_r    <= msb_index(x_b);
          m_r    <= norm(x_b, msb_index(x_b));
          frac_r <= '0;
        end else begin
          m_r    <= m_step;
          frac_r <= frac_step;
        end
      end
      CU_LOGB: begin
        cnt_r  <= cnt_r + 5'd1;
        m_r    <= m_step;
        frac_r <= frac_step;
        if (cnt_r == 5'd31) dh_r <= ldiff[LOG_W-1:8];
      end
      CU_MLO: pl_r <= mul_p[43:0];
      CU_MHI: ph_r <= mul_p[43:0];
      CU_SUM: begin
        cost_r <= cost_sat;
        dv_r   <= cost_sat;
        rem_r  <= '0;
        cnt_r  <= '0;
      end
      CU_DIV: begin
        cnt_r <= cnt_r + 5'd1;
        rem_r <= q_bit ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
        dv_r  <= {dv_r[DIST_W-2:0], q_bit};
      end
      default: ;
    endcase
  end

  assign done          = done_r;
  assign result.full   = cost_r;
  assign result.scaled = dv_r;

endmodule

// ----- design/wed_dp_engine.sv -----
// Cost table engine: character and cost stores, row buffer, shared add/min unit.
module wed_dp_engine #(
  parameter int MAX_LEN  = 32,
  localparam int LEN_W   = $clog2(MAX_LEN + 1),
  localparam int IDX_W   = $clog2(MAX_LEN)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // character loads
  input  logic                       ld_we,
  input  logic                       ld_query,
  input  logic [IDX_W-1:0]           ld_addr,
  input  logic [wed_pkg::CHAR_W-1:0] ld_char,
  // per-position cost writes
  input  logic                       cm_we,
  input  logic                       cm_query,
  input  logic [IDX_W-1:0]           cm_addr,
  input  wed_pkg::wed_qcost_t        cm_data,
  // table run
  input  logic                       start,
  input  logic [LEN_W-1:0]           n,
  input  logic [LEN_W-1:0]           m,
  output logic                       done,
  output logic [wed_pkg::DIST_W-1:0] distance
);
  import wed_pkg::*;

  localparam int RA_W = LEN_W + 2;

  localparam logic [3:0] E_IDLE  = 4'd0;
  localparam logic [3:0] E_ROW   = 4'd1;
  localparam logic [3:0] E_RD    = 4'd2;
  localparam logic [3:0] E_LAT   = 4'd3;
  localparam logic [3:0] E_DIAG  = 4'd4;
  localparam logic [3:0] E_TRANS = 4'd5;
  localparam logic [3:0] E_LEFT  = 4'd6;
  localparam logic [3:0] E_UP    = 4'd7;
  localparam logic [3:0] E_WR    = 4'd8;

  // Stores
  logic [CHAR_W-1:0] wchar_mem [MAX_LEN];
  logic [CHAR_W-1:0] qchar_mem [MAX_LEN];
  wed_qcost_t        qcost_mem [MAX_LEN];
  logic [DIST_W-1:0] wdel_mem  [MAX_LEN];
  logic [DIST_W-1:0] row_mem   [1 << RA_W];

  logic [CHAR_W-1:0] wchar_q, qchar_q;
  wed_qcost_t        qcost_q;
  logic [DIST_W-1:0] wdel_q, up_q, tr_q;

  logic [3:0]        state_r, state_nxt;
  logic              done_r;
  logic [LEN_W-1:0]  i_r, j_r, n_r, m_r;
  logic [CHAR_W-1:0] w_cur_r, w_prev_r, q_cur_r, q_prev_r;
  logic [DIST_W-1:0] dw_r, cq_cur_r, cq_prev_r, dq_cur_r;
  logic [DIST_W-1:0] up_r, diag_r, tr_r, left_r, acc_r, dist_r;

  logic [LEN_W-1:0]  im1, im2, jm1, jm2;
  logic [RA_W-1:0]   up_addr, tr_addr, wr_addr;
  logic              row_end, tab_end;

  logic              en;
  logic [DIST_W-1:0] base, add;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] cand;

  assign im1     = i_r - LEN_W'(1);
  assign im2     = i_r - LEN_W'(2);
  assign jm1     = j_r - LEN_W'(1);
  assign jm2     = j_r - LEN_W'(2);
  assign up_addr = {im1[1:0], j_r};
  assign tr_addr = {im2[1:0], jm2};
  assign wr_addr = {i_r[1:0], j_r};
  assign row_end = (j_r == m_r);
  assign tab_end = row_end && (i_r == n_r);

  // Character stores
  always_ff @(posedge clk) begin
    if (ld_we && !ld_query) wchar_mem[ld_addr] <= ld_char;
    if (state_r == E_ROW) wchar_q <= wchar_mem[im1[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ld_we && ld_query) qchar_mem[ld_addr] <= ld_char;
    if (state_r == E_RD) qchar_q <= qchar_mem[jm1[IDX_W-1:0]];
  end

  // Cost stores
  always_ff @(posedge clk) begin
    if (cm_we && cm_query) qcost_mem[cm_addr] <= cm_data;
    if (state_r == E_RD) qcost_q <= qcost_mem[jm1[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cm_we && !cm_query) wdel_mem[cm_addr] <= cm_data.del;
    if (state_r == E_ROW) wdel_q <= wdel_mem[im1[IDX_W-1:0]];
  end

  // Row buffer: four row slots, reads of the previous two rows
  always_ff @(posedge clk) begin
    if (state_r == E_WR) row_mem[wr_addr] <= acc_r;
    if (state_r == E_RD) begin
      up_q <= row_mem[up_addr];
      tr_q <= row_mem[tr_addr];
    end
  end

  // Shared add/saturate/min unit
  always_comb begin
    en   = 1'b0;
    base = acc_r;
    add  = '0;
    case (state_r)
      E_DIAG: begin
        en   = (i_r != '0) && (j_r != '0);
        base = diag_r;
        add  = (w_cur_r == q_cur_r) ? '0 : cq_cur_r;
      end
      E_TRANS: begin
        en   = (i_r > LEN_W'(1)) && (j_r > LEN_W'(1)) &&
               (w_prev_r == q_cur_r) && (w_cur_r == q_prev_r);
        base = tr_r;
        add  = cq_prev_r >> 1;
      end
      E_LEFT: begin
        en   = (j_r != '0);
        base = left_r;
        add  = dq_cur_r;
      end
      E_UP: begin
        en   = (i_r != '0);
        base = up_r;
        add  = dw_r;
      end
      default: ;
    endcase
  end
  assign sum  = {1'b0, base} + {1'b0, add};
  assign cand = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];

  // Cell sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      E_IDLE:  if (start) state_nxt = E_ROW;
      E_ROW:   state_nxt = E_RD;
      E_RD:    state_nxt = E_LAT;
      E_LAT:   state_nxt = E_DIAG;
      E_DIAG:  state_nxt = E_TRANS;
      E_TRANS: state_nxt = E_LEFT;
      E_LEFT:  state_nxt = E_UP;
      E_UP:    state_nxt = E_WR;
      E_WR: begin
        if (tab_end)      state_nxt = E_IDLE;
        else if (row_end) state_nxt = E_ROW;
        else              state_nxt = E_RD;
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == E_WR) && tab_end;
    end
  end

  // Cell datapath
  always_ff @(posedge clk) begin
    case (state_r)
      E_IDLE: begin
        if (start) begin
          n_r <= n;
          m_r <= m;
          i_r <= '0;
          j_r <= '0;
        end
      end
      E_LAT: begin
        if (j_r == '0) begin
          w_prev_r <= w_cur_r;
          w_cur_r  <= wchar_q;
          dw_r     <= wdel_q;
        end
        q_prev_r  <= q_cur_r;
        q_cur_r   <= qchar_q;
        cq_prev_r <= cq_cur_r;
        cq_cur_r  <= qcost_q.sub;
        dq_cur_r  <= qcost_q.del;
        diag_r    <= up_r;
        up_r      <= up_q;
        tr_r      <= tr_q;
        acc_r     <= ((i_r == '0) && (j_r == '0)) ? '0 : DIST_MAX;
      end
      E_DIAG, E_TRANS, E_LEFT, E_UP: begin
        if (en && (cand < acc_r)) acc_r <= cand;
      end
      E_WR: begin
        left_r <= acc_r;
        if (tab_end) begin
          dist_r <= acc_r;
        end else if (row_end) begin
          i_r <= i_r + LEN_W'(1);
          j_r <= '0;
        end else begin
          j_r <= j_r + LEN_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign done     = done_r;
  assign distance = dist_r;

endmodule

// ----- design/weighted_edit_distance_core.sv -----
// Top level of the weighted edit distance core: loading, cost preparation, result register.
//
//   channel  ports                         payload     transfer when
//   input    in_valid/in_ready/in_data     wed_in_t    in_valid & in_ready
//   result   out_valid/out_ready/out_data  wed_out_t   out_valid & out_ready
//
// Character loads and no-op requests may follow back to back.
// A compute first runs the cost unit once per query and word position
// (start, two 32-step log2 squarings, two partial products and their rounded sum, a 27-step
// divide, done), then fills the table cell by cell on the single add/min unit, with a row
// setup step before each row; in_ready is low meanwhile.
// Reset is synchronous and clears lengths, flags and control; stores are not cleared.
// A pending result waits in the output register while further loads are taken; a compute
// that finishes while the register is still full holds until it is taken.
module weighted_edit_distance_core #(
  parameter int MAX_LEN   = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wed_pkg::wed_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wed_pkg::wed_out_t out_data
);
  import wed_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);

  localparam logic [2:0] T_IDLE   = 3'd0;
  localparam logic [2:0] T_QSTART = 3'd1;
  localparam logic [2:0] T_QWAIT  = 3'd2;
  localparam logic [2:0] T_WSTART = 3'd3;
  localparam logic [2:0] T_WWAIT  = 3'd4;
  localparam logic [2:0] T_DP     = 3'd5;
  localparam logic [2:0] T_DPWAIT = 3'd6;
  localparam logic [2:0] T_OUT    = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [LEN_W-1:0]  word_len_r, query_len_r;
  logic              word_closed_r, query_closed_r;
  logic              overflow_r;
  logic [MAX_LEN-1:0] word_dup_r, query_dup_r;
  logic [CHAR_W-1:0] word_prev_r, query_prev_r;
  logic [LEN_W-1:0]  n_r, m_r, k_r;
  logic              out_valid_r;
  wed_out_t          out_data_r;

  logic              in_xfer;
  logic              is_word, is_query;
  logic [LEN_W-1:0]  eff_len;
  logic              room;
  logic [CHAR_W-1:0] prev_char;

  logic              prep_query;
  logic [LEN_W-1:0]  len_sel;
  logic              k_last;
  logic              dup_sel;

  logic              cu_start, cu_done;
  wed_cost_t         cu_res;
  logic              cm_we;
  wed_qcost_t        cm_data;
  logic              eng_start, eng_done;
  logic [DIST_W-1:0] eng_dist;

  assign in_ready = (state_r == T_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign is_word  = (in_data.req_type == REQ_WORD);
  assign is_query = (in_data.req_type == REQ_QUERY);

  // Load position: a closed string starts over
  always_comb begin
    if (is_query) begin
      eff_len   = query_closed_r ? '0 : query_len_r;
      prev_char = query_prev_r;
    end else begin
      eff_len   = word_closed_r ? '0 : word_len_r;
      prev_char = word_prev_r;
    end
  end
  assign room = (eff_len < LEN_W'(MAX_LEN));

  // Cost preparation selects
  assign prep_query = (state_r == T_QSTART) || (state_r == T_QWAIT);
  assign len_sel    = prep_query ? m_r : n_r;
  assign k_last     = ((k_r + LEN_W'(1)) == len_sel);
  assign dup_sel    = (prep_query ? query_dup_r[k_r[IDX_W-1:0]] : word_dup_r[k_r[IDX_W-1:0]]) &&
                      ((k_r + LEN_W'(1)) < len_sel);
  assign cu_start   = (state_r == T_QSTART) || (state_r == T_WSTART);
  assign cm_we      = cu_done && ((state_r == T_QWAIT) || (state_r == T_WWAIT));
  assign cm_data.sub = cu_res.full;
  assign cm_data.del = dup_sel ? cu_res.scaled : cu_res.full;
  assign eng_start  = (state_r == T_DP);

  // Request sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: begin
        if (in_xfer && (in_data.req_type == REQ_COMPUTE)) begin
          if (query_len_r != '0)     state_nxt = T_QSTART;
          else if (word_len_r != '0) state_nxt = T_WSTART;
          else                       state_nxt = T_DP;
        end
      end
      T_QSTART: state_nxt = T_QWAIT;
      T_QWAIT: begin
        if (cu_done) begin
          if (!k_last)          state_nxt = T_QSTART;
          else if (n_r != '0)   state_nxt = T_WSTART;
          else                  state_nxt = T_DP;
        end
      end
      T_WSTART: state_nxt = T_WWAIT;
      T_WWAIT: begin
        if (cu_done) state_nxt = k_last ? T_DP : T_WSTART;
      end
      T_DP:     state_nxt = T_DPWAIT;
      T_DPWAIT: if (eng_done) state_nxt = T_OUT;
      T_OUT:    if (!out_valid_r || out_ready) state_nxt = T_IDLE;
      default:  state_nxt = T_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= T_IDLE;
      word_len_r     <= '0;
      query_len_r    <= '0;
      word_closed_r  <= 1'b1;
      query_closed_r <= 1'b1;
      overflow_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (in_xfer && is_word) begin
        word_len_r    <= room ? eff_len + LEN_W'(1) : eff_len;
        word_closed_r <= in_data.last;
        if (!room) overflow_r <= 1'b1;
      end
      if (in_xfer && is_query) begin
        query_len_r    <= room ? eff_len + LEN_W'(1) : eff_len;
        query_closed_r <= in_data.last;
        if (!room) overflow_r <= 1'b1;
      end
      if ((state_r == T_OUT) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        overflow_r  <= 1'b0;
      end
    end
  end

  // Payload and bookkeeping registers
  always_ff @(posedge clk) begin
    if (in_xfer && (is_word || is_query) && room) begin
      if (is_word) begin
        word_prev_r <= in_data.char_code;
        if (eff_len != '0)
          word_dup_r[IDX_W'(eff_len - LEN_W'(1))] <= (in_data.char_code == prev_char);
      end else begin
        query_prev_r <= in_data.char_code;
        if (eff_len != '0)
          query_dup_r[IDX_W'(eff_len - LEN_W'(1))] <= (in_data.char_code == prev_char);
      end
    end
    if (in_xfer && (in_data.req_type == REQ_COMPUTE)) begin
      n_r <= word_len_r;
      m_r <= query_len_r;
      k_r <= '0;
    end
    if (cm_we) k_r <= k_last ? '0 : k_r + LEN_W'(1);
    if ((state_r == T_OUT) && (!out_valid_r || out_ready)) begin
      out_data_r.distance     <= eng_dist;
      out_data_r.length_error <= overflow_r;
    end
  end

  wed_cost_unit #(
    .MAX_LEN   (MAX_LEN),
    .FRAC_BITS (FRAC_BITS)
  ) u_cost (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cu_start),
    .pos    (k_r),
    .len    (len_sel),
    .done   (cu_done),
    .result (cu_res)
  );

  wed_dp_engine #(
    .MAX_LEN (MAX_LEN)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_we    (in_xfer && (is_word || is_query) && room),
    .ld_query (is_query),
    .ld_addr  (eff_len[IDX_W-1:0]),
    .ld_char  (in_data.char_code),
    .cm_we    (cm_we),
    .cm_query (prep_query),
    .cm_addr  (k_r[IDX_W-1:0]),
    .cm_data  (cm_data),
    .start    (eng_start),
    .n        (n_r),
    .m        (m_r),
    .done     (eng_done),
    .distance (eng_dist)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- dv/tb_weighted_edit_distance_core.sv -----
// Self-checking testbench for the weighted edit distance core.
`timescale 1ns / 100ps

module tb_weighted_edit_distance_core;
  import wed_pkg::*;

  localparam int MAX_LEN     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int ITEM_TARGET = 1150;
  localparam int LIMIT       = 50_000_000;
  localparam int TAIL_CYCLES = 200;
  localparam int ROUND_SH    = 56 - FRAC_BITS;
  localparam logic [63:0] FIVE_LN2 = 64'd14885222359;
  // String indexes in the shadow stores
  localparam int WORD_S  = 0;
  localparam int QUERY_S = 1;
  localparam int NUM_ROWS = 25;

  typedef logic [7:0] text_t[$];

  // One row of the directed plan; fixed fields override the prediction
  typedef struct packed {
    logic [1:0]        req;
    logic [7:0]        ch;
    logic              last;
    logic [7:0]        rep;
    logic              fix_dist;
    logic [DIST_W-1:0] want_dist;
    logic              fix_err;
    logic              err;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  wed_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  wed_out_t out_data;

  // Shadow state of the core
  logic [7:0]        str_chars [2][MAX_LEN];
  int                str_len [2] = '{0, 0};
  bit                str_closed [2] = '{1'b1, 1'b1};
  bit                len_overflow = 1'b0;
  logic [DIST_W-1:0] cost_tbl [0:MAX_LEN][0:MAX_LEN];

  wed_out_t  pending_dist[$];
  plan_row_t plan [NUM_ROWS];
  logic [7:0] alpha [4];
  int alpha_n = 2;

  int  errors = 0;
  int  items_sent = 0;
  int  dist_checked = 0;
  int  trunc_results = 0;
  int  longest_word = 0;
  int  longest_query = 0;
  int  cycle_count = 0;
  int  rx_wait = 0;
  bit  burst_mode = 1'b0;

  weighted_edit_distance_core #(
    .MAX_LEN  (MAX_LEN),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // log2 with 32 fraction bits, one fraction bit per squaring step
  function automatic logic [63:0] log2_fx(int unsigned x);
    int unsigned xv;
    int unsigned e;
    logic [63:0] mant;
    logic [63:0] frac;
    xv = x & 127;
    if (xv == 0) xv = 1;
    e = 0;
    frac = '0;
    while ((xv >> (e + 1)) != 0) e++;
    mant = 64'(xv) << (30 - e);
    for (int b = 31; b >= 0; b--) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        frac[b] = 1'b1;
      end
    end
    return (64'(e) << 32) | frac;
  endfunction

  // 5*ln((len+2)/(pos+1)) rounded to FRAC_BITS fraction bits
  function automatic logic [DIST_W-1:0] pos_cost(int pos, int len);
    logic [63:0] la;
    logic [63:0] lb;
    logic [63:0] diff;
    logic [63:0] prod;
    logic [63:0] rnd;
    la = log2_fx(len + 2);
    lb = log2_fx(pos + 1);
    diff = (la > lb) ? la - lb : 64'd0;
    prod = (diff >> 8) * FIVE_LN2;
    rnd = (prod + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
    return (rnd > 64'(DIST_MAX)) ? DIST_MAX : rnd[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] sat_sum(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, DIST_MAX}) ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  function automatic void relax(int i, int j, logic [DIST_W-1:0] v);
    if (v < cost_tbl[i][j]) cost_tbl[i][j] = v;
  endfunction

  // Fill the full cost table over rows 0..n and columns 0..m
  function automatic logic [DIST_W-1:0] edit_distance();
    int n;
    int m;
    logic [DIST_W-1:0] cur;
    logic [DIST_W-1:0] cq;
    logic [DIST_W-1:0] qc [MAX_LEN];
    logic [DIST_W-1:0] wc [MAX_LEN];
    n = str_len[WORD_S];
    m = str_len[QUERY_S];
    for (int k = 0; k < m; k++) qc[k] = pos_cost(k, m);
    for (int k = 0; k < n; k++) wc[k] = pos_cost(k, n);
    for (int i = 0; i <= n; i++)
      for (int j = 0; j <= m; j++) cost_tbl[i][j] = DIST_MAX;
    cost_tbl[0][0] = '0;
    for (int i = 0; i <= n; i++) begin
      for (int j = 0; j <= m; j++) begin
        cur = cost_tbl[i][j];
        cq = (j < m) ? qc[j] : '0;
        // match or substitution
        if (i < n && j < m) begin
          if (str_chars[WORD_S][i] == str_chars[QUERY_S][j]) relax(i + 1, j + 1, cur);
          else relax(i + 1, j + 1, sat_sum(cur, cq));
        end
        // swapped neighbors
        if (i + 1 < n && j + 1 < m &&
            str_chars[WORD_S][i] == str_chars[QUERY_S][j + 1] &&
            str_chars[WORD_S][i + 1] == str_chars[QUERY_S][j])
          relax(i + 2, j + 2, sat_sum(cur, cq >> 1));
        // query deletion, cheap on a doubled letter
        if (j < m) begin
          if (j + 1 < m && str_chars[QUERY_S][j] == str_chars[QUERY_S][j + 1])
            relax(i, j + 1, sat_sum(cur, DIST_W'(cq / m)));
          else
            relax(i, j + 1, sat_sum(cur, cq));
        end
        // word deletion, cheap on a doubled letter
        if (i < n) begin
          if (i + 1 < n && str_chars[WORD_S][i] == str_chars[WORD_S][i + 1])
            relax(i + 1, j, sat_sum(cur, DIST_W'(wc[i] / n)));
          else
            relax(i + 1, j, sat_sum(cur, wc[i]));
        end
      end
    end
    return cost_tbl[n][m];
  endfunction

  // Update the shadow state for one accepted request
  function automatic void predict_request(input wed_in_t it, output bit produced,
                                          output wed_out_t res);
    int s;
    produced = 1'b0;
    res = '0;
    case (it.req_type)
      REQ_WORD, REQ_QUERY: begin
        s = (it.req_type == REQ_WORD) ? WORD_S : QUERY_S;
        if (str_closed[s]) begin
          str_len[s] = 0;
          str_closed[s] = 1'b0;
        end
        if (str_len[s] < MAX_LEN) begin
          str_chars[s][str_len[s]] = it.char_code;
          str_len[s]++;
        end else begin
          len_overflow = 1'b1;
        end
        if (it.last) str_closed[s] = 1'b1;
      end
      REQ_COMPUTE: begin
        res.distance = edit_distance();
        res.length_error = len_overflow;
        len_overflow = 1'b0;
        produced = 1'b1;
        if (str_len[WORD_S] > longest_word) longest_word = str_len[WORD_S];
        if (str_len[QUERY_S] > longest_query) longest_query = str_len[QUERY_S];
      end
      default: ;
    endcase
  endfunction

  function automatic wed_in_t req_item(logic [1:0] req, logic [7:0] ch, logic lst);
    wed_in_t it;
    it.req_type = req;
    it.char_code = ch;
    it.last = lst;
    return it;
  endfunction

  // Drive one request after a random gap (none in burst mode) and wait for its transfer
  task automatic issue(input wed_in_t it, input bit fix_d = 1'b0,
                       input logic [DIST_W-1:0] want_d = '0,
                       input bit fix_e = 1'b0, input bit want_e = 1'b0);
    int gap;
    bit produced;
    wed_out_t res;
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_request(it, produced, res);
    if (produced) begin
      if (fix_d) res.distance = want_d;
      if (fix_e) res.length_error = want_e;
      if (res.length_error) trunc_results++;
      pending_dist.insert(pending_dist.size(), res);
    end
    if (it.req_type != REQ_NOP) items_sent++;
  endtask

  task automatic compute_now();
    issue(req_item(REQ_COMPUTE, 8'($urandom), 1'($urandom)));
  endtask

  // Sender holds off until every outstanding distance is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_dist.size() != 0) @(posedge clk);
  endtask

  function automatic void new_alphabet();
    alpha_n = $urandom_range(2, 4);
    foreach (alpha[k]) alpha[k] = 8'($urandom);
  endfunction

  // Mostly letters from a small alphabet, so matches, swaps and doubles are common
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return alpha[$urandom_range(0, alpha_n - 1)];
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 16);
    return $urandom_range(30, 36);
  endfunction

  function automatic text_t make_text(int len);
    text_t t;
    for (int k = 0; k < len; k++) t.insert(t.size(), pick_char());
    return t;
  endfunction

  // One random edit of a word: swap, drop, replace or double a letter; a word under two letters gets one appended
  function automatic text_t mutate(text_t src);
    text_t t;
    int p;
    logic [7:0] tmp;
    t = src;
    if (t.size() < 2) begin
      t.insert(t.size(), pick_char());
      return t;
    end
    p = $urandom_range(0, t.size() - 2);
    case ($urandom_range(0, 3))
      0: begin
        tmp = t[p];
        t[p] = t[p + 1];
        t[p + 1] = tmp;
      end
      1: t.delete(p);
      2: t[p] = pick_char();
      default: t.insert(p, t[p]);
    endcase
    return t;
  endfunction

  task automatic load_text(input logic [1:0] kind, input text_t txt, input bit close);
    foreach (txt[k]) begin
      if ($urandom_range(0, 19) == 0) issue(req_item(REQ_NOP, 8'($urandom), 1'($urandom)));
      issue(req_item(kind, txt[k], close && (k == txt.size() - 1)));
    end
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d distances outstanding",
               $time, cycle_count, pending_dist.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stalls and field-by-field compare
  always @(posedge clk) begin : result_check
    wed_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_dist.size() == 0) begin
          errors++;
          $display("%0t: unexpected result distance=%0d length_error=%0b",
                   $time, out_data.distance, out_data.length_error);
        end else begin
          want = pending_dist.pop_front();
          dist_checked++;
          if (out_data.distance !== want.distance) begin
            errors++;
            $display("%0t: distance mismatch expected=%0d actual=%0d",
                     $time, want.distance, out_data.distance);
          end
          if (out_data.length_error !== want.length_error) begin
            errors++;
            $display("%0t: length_error mismatch expected=%0b actual=%0b",
                     $time, want.length_error, out_data.length_error);
          end
        end
        rx_wait = burst_mode ? 0 : $urandom_range(0, 6);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_ready <= (rx_wait == 0);
    end
  end

  // Stimulus
  initial begin : stimulus
    text_t wtxt;
    text_t qtxt;
    int pick;
    logic [1:0] sel;

    plan = '{
      // empty strings after reset
      '{REQ_COMPUTE, 8'h00, 1'b0, 8'd1,  1'b1, 27'd0, 1'b1, 1'b0},
      '{REQ_NOP,     8'hFF, 1'b1, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      // word only, query still empty
      '{REQ_WORD,    8'h41, 1'b1, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_COMPUTE, 8'hFF, 1'b1, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      // extreme bytes, identical strings
      '{REQ_WORD,    8'h00, 1'b0, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_WORD,    8'hFF, 1'b1, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_QUERY,   8'h00, 1'b0, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_QUERY,   8'hFF, 1'b1, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_COMPUTE, 8'h00, 1'b0, 8'd1,  1'b1, 27'd0, 1'b1, 1'b0},
      // swapped pair
      '{REQ_WORD,    8'h12, 1'b0, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_WORD,    8'h34, 1'b1, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_QUERY,   8'h34, 1'b0, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_QUERY,   8'h12, 1'b1, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_COMPUTE, 8'h00, 1'b0, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      // tripled letter in the word, compute while the query is open
      '{REQ_WORD,    8'h55, 1'b1, 8'd3,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_QUERY,   8'h55, 1'b0, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_COMPUTE, 8'h00, 1'b0, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_QUERY,   8'h66, 1'b1, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_COMPUTE, 8'h00, 1'b0, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      // over-long word, full-length query, flag reported once then cleared
      '{REQ_WORD,    8'hAA, 1'b1, 8'd33, 1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_QUERY,   8'hAA, 1'b1, 8'd32, 1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_COMPUTE, 8'h00, 1'b0, 8'd1,  1'b1, 27'd0, 1'b1, 1'b1},
      '{REQ_COMPUTE, 8'h00, 1'b0, 8'd1,  1'b1, 27'd0, 1'b1, 1'b0},
      // longest word against a single character
      '{REQ_QUERY,   8'h3C, 1'b1, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0},
      '{REQ_COMPUTE, 8'h00, 1'b0, 8'd1,  1'b0, 27'd0, 1'b0, 1'b0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan
    foreach (plan[r]) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < int'(plan[r].rep); k++)
        issue(req_item(plan[r].req, plan[r].ch, plan[r].last && (k == plan[r].rep - 1)),
              plan[r].fix_dist, plan[r].want_dist, plan[r].fix_err, plan[r].err);
    end
    drain_results();

    // Random sequences, mostly complete word/query/compute triples
    while (items_sent < ITEM_TARGET) begin
      burst_mode = ($urandom_range(0, 6) == 0);
      new_alphabet();
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        wtxt = make_text(pick_len());
        if ($urandom_range(0, 9) < 4) qtxt = mutate(wtxt);
        else qtxt = make_text(pick_len());
        if ($urandom_range(0, 3) != 0) begin
          load_text(REQ_WORD, wtxt, 1'b1);
          load_text(REQ_QUERY, qtxt, 1'b1);
        end else begin
          load_text(REQ_QUERY, qtxt, 1'b1);
          load_text(REQ_WORD, wtxt, 1'b1);
        end
        compute_now();
      end else if (pick < 75) begin
        // replace one string, keep the other
        sel = $urandom_range(0, 1) ? REQ_QUERY : REQ_WORD;
        load_text(sel, make_text(pick_len()), 1'b1);
        compute_now();
      end else if (pick < 83) begin
        // compute on an open string, then finish it
        sel = $urandom_range(0, 1) ? REQ_QUERY : REQ_WORD;
        load_text(sel, make_text($urandom_range(1, 4)), 1'b0);
        compute_now();
        load_text(sel, make_text($urandom_range(1, 3)), 1'b1);
        compute_now();
      end else if (pick < 88) begin
        compute_now();
      end else begin
        repeat ($urandom_range(1, 5))
          issue(req_item(2'($urandom), 8'($urandom), 1'($urandom)));
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    // Wind down
    in_valid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests; checked %0d distances, %0d of them with a truncated string",
             items_sent, dist_checked, trunc_results);
    $display("Longest word %0d and longest query %0d characters at compute time",
             longest_word, longest_query);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
